// ===== sv/ccol_pkg.sv =====
// Shared widths, status codes and stage records for the circle contact-time pipeline.
package ccol_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LEAD_W    = 16;
  localparam int POS_W     = 32;
  localparam int RAD_W     = 24;
  localparam int TIME_W    = 48;

  localparam int DIF_W  = POS_W + 1;     // relative position / velocity
  localparam int RS_W   = RAD_W + 1;     // summed radius
  localparam int MAG_W  = 2 * DIF_W;     // magnitudes of a, b, c
  localparam int HALF_W = DIF_W;         // split point for wide products
  localparam int QW     = MAG_W + 2;     // signed b and c
  localparam int PW     = 2 * MAG_W;     // b*b and a*c
  localparam int SQ_W   = PW + 2;        // signed discriminant / radicand
  localparam int ROOT_W = SQ_W / 2;      // square root bits, one per cell
  localparam int SQR_W  = ROOT_W + 3;    // root cell remainder
  localparam int NUM_W  = QW + 1;        // -b - root
  localparam int DVR_W  = MAG_W + 2;     // divider partial remainder
  localparam int DVT_W  = DVR_W + TIME_W;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_STILL = 2'd1,
    ST_MISS  = 2'd2,
    ST_SOON  = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  first_pos_x;
    logic [POS_W-1:0]  first_pos_y;
    logic [POS_W-1:0]  first_vel_x;
    logic [POS_W-1:0]  first_vel_y;
    logic [RAD_W-1:0]  first_radius;
    logic [POS_W-1:0]  second_pos_x;
    logic [POS_W-1:0]  second_pos_y;
    logic [POS_W-1:0]  second_vel_x;
    logic [POS_W-1:0]  second_vel_y;
    logic [RAD_W-1:0]  second_radius;
    logic [TIME_W-1:0] current_time;
  } in_t;

  typedef struct packed {
    status_t           st;
    logic              sat;
    logic [MAG_W-1:0]  a;
    logic [QW-1:0]     b;
    logic [TIME_W-1:0] now;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   rad;
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic              valid;
    logic [DVR_W-1:0]  rem;
    logic [TIME_W-1:0] dend;
    logic [TIME_W-1:0] quo;
    side_t             side;
  } dv_t;

endpackage

// ===== sv/circle_collision_time.sv =====
// Top level: request buffer, root and divider cell chains, final time and result register.
//
// Predicts the absolute time of first contact of two moving circles. One pair
// is taken every cycle while the result side does not stall, and it passes
// through the request buffer, the front coefficient pipeline (8 stages), a
// chain of 67 square-root cells (one root bit each), two stages forming the
// numerator, a chain of 48 divider cells (one time bit each) and the result
// register. When the result is not taken the whole pipeline holds, while one
// more request can still be parked in the input buffer. A status of 1 means
// no relative motion, 2 no contact (grazing counts as none), 3 a contact at or
// before min_lead_time from now; event_time is zero unless hit is set and
// saturates to all ones.
module circle_collision_time (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ccol_pkg::LEAD_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ccol_pkg::POS_W-1:0]    first_pos_x,
  input  logic [ccol_pkg::POS_W-1:0]    first_pos_y,
  input  logic [ccol_pkg::POS_W-1:0]    first_vel_x,
  input  logic [ccol_pkg::POS_W-1:0]    first_vel_y,
  input  logic [ccol_pkg::RAD_W-1:0]    first_radius,
  input  logic [ccol_pkg::POS_W-1:0]    second_pos_x,
  input  logic [ccol_pkg::POS_W-1:0]    second_pos_y,
  input  logic [ccol_pkg::POS_W-1:0]    second_vel_x,
  input  logic [ccol_pkg::POS_W-1:0]    second_vel_y,
  input  logic [ccol_pkg::RAD_W-1:0]    second_radius,
  input  logic [ccol_pkg::TIME_W-1:0]   current_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [1:0]                    status,
  output logic [ccol_pkg::TIME_W-1:0]   event_time
);

  logic                        en;
  logic                        accept;
  logic [ccol_pkg::LEAD_W-1:0] min_lead;
  ccol_pkg::in_t               ireg;

  ccol_pkg::sq_t sq [ccol_pkg::ROOT_W+1];
  ccol_pkg::dv_t dv [ccol_pkg::TIME_W+1];

  logic                          n1_valid;
  logic [ccol_pkg::NUM_W-1:0]    n1_num;
  ccol_pkg::side_t               n1_side;
  ccol_pkg::side_t               n1_side_next;
  ccol_pkg::side_t               dv0_side_next;
  logic [ccol_pkg::NUM_W-1:0]    num_c;
  logic [ccol_pkg::DVT_W-1:0]    nsh;
  logic                          big;

  ccol_pkg::side_t               fin;
  logic [ccol_pkg::TIME_W-1:0]   t;
  logic [ccol_pkg::TIME_W:0]     tsum;
  ccol_pkg::status_t             st_fin;

  // advance the pipeline unless a result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en || !ireg.valid;
  assign accept   = in_valid && in_ready;

  // lead-time register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_lead <= ccol_pkg::LEAD_W'(1);
    end else if (cfg_wr_en) begin
      min_lead <= cfg_wr_data;
    end
  end

  // request buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg.valid <= 1'b0;
    end else begin
      ireg.valid <= accept || (ireg.valid && !en);
    end
    if (accept) begin
      ireg.first_pos_x   <= first_pos_x;
      ireg.first_pos_y   <= first_pos_y;
      ireg.first_vel_x   <= first_vel_x;
      ireg.first_vel_y   <= first_vel_y;
      ireg.first_radius  <= first_radius;
      ireg.second_pos_x  <= second_pos_x;
      ireg.second_pos_y  <= second_pos_y;
      ireg.second_vel_x  <= second_vel_x;
      ireg.second_vel_y  <= second_vel_y;
      ireg.second_radius <= second_radius;
      ireg.current_time  <= current_time;
    end
  end

  ccol_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d_in  (ireg),
    .d_out (sq[0])
  );

  // square-root chain
  for (genvar k = 0; k < ccol_pkg::ROOT_W; k++) begin : g_sqrt
    ccol_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (sq[k]),
      .d_out (sq[k+1])
    );
  end

  // numerator -b - root; drop roots not ahead
  assign num_c = ccol_pkg::NUM_W'(0)
               - {sq[ccol_pkg::ROOT_W].side.b[ccol_pkg::QW-1], sq[ccol_pkg::ROOT_W].side.b}
               - {2'b00, sq[ccol_pkg::ROOT_W].root};

  always_comb begin
    n1_side_next = sq[ccol_pkg::ROOT_W].side;
    if (sq[ccol_pkg::ROOT_W].side.st == ccol_pkg::ST_HIT &&
        (num_c[ccol_pkg::NUM_W-1] || num_c == '0)) begin
      n1_side_next.st = ccol_pkg::ST_SOON;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
    end else if (en) begin
      n1_valid <= sq[ccol_pkg::ROOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_num  <= num_c;
      n1_side <= n1_side_next;
    end
  end

  // scale numerator, check for quotient overflow, load first divider cell
  assign nsh = ccol_pkg::DVT_W'(n1_num) << ccol_pkg::FRAC_BITS;
  assign big = nsh >= (ccol_pkg::DVT_W'(n1_side.a) << ccol_pkg::TIME_W);

  always_comb begin
    dv0_side_next     = n1_side;
    dv0_side_next.sat = big;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (en) begin
      dv[0].valid <= n1_valid;
    end
    if (en) begin
      dv[0].rem  <= nsh[ccol_pkg::DVT_W-1:ccol_pkg::TIME_W];
      dv[0].dend <= nsh[ccol_pkg::TIME_W-1:0];
      dv[0].quo  <= '0;
      dv[0].side <= dv0_side_next;
    end
  end

  // divider chain
  for (genvar k = 0; k < ccol_pkg::TIME_W; k++) begin : g_div
    ccol_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (dv[k]),
      .d_out (dv[k+1])
    );
  end

  // lead-time check and absolute time
  always_comb begin
    fin  = dv[ccol_pkg::TIME_W].side;
    t    = fin.sat ? '1 : dv[ccol_pkg::TIME_W].quo;
    tsum = {1'b0, fin.now} + {1'b0, t};
    if (fin.st == ccol_pkg::ST_HIT && t <= ccol_pkg::TIME_W'(min_lead)) begin
      st_fin = ccol_pkg::ST_SOON;
    end else begin
      st_fin = fin.st;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[ccol_pkg::TIME_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit    <= (st_fin == ccol_pkg::ST_HIT);
      status <= st_fin;
      if (st_fin != ccol_pkg::ST_HIT) begin
        event_time <= '0;
      end else if (tsum[ccol_pkg::TIME_W]) begin
        event_time <= '1;
      end else begin
        event_time <= tsum[ccol_pkg::TIME_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ireg.valid && out_valid && !out_ready)
    else $error("request refused with room in the pipeline");

  a_buf_hold: assert property (@(posedge clk) disable iff (rst)
    ireg.valid && !en |=> ireg.valid && $stable(ireg))
    else $error("parked request changed while stalled");

  a_lead_wr: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> min_lead == $past(cfg_wr_data))
    else $error("lead-time write lost");
`endif

endmodule

// ===== sv/ccol_front.sv =====
// Front pipeline: relative motion, quadratic coefficients and discriminant.
module ccol_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ccol_pkg::in_t d_in,
  output ccol_pkg::sq_t d_out
);

  logic v1, v2, v3, v4, v5, v6, v7;

  logic signed [ccol_pkg::DIF_W-1:0] dx, dy, vx, vy;
  logic [ccol_pkg::RS_W-1:0]         rs;
  logic [ccol_pkg::TIME_W-1:0]       now1, now2, now3, now4, now5, now6, now7;

  logic signed [ccol_pkg::MAG_W-1:0] pvx, pvy, pbx, pby, pdx, pdy;
  logic [2*ccol_pkg::RS_W-1:0]       prr;

  logic [ccol_pkg::MAG_W-1:0]        a3, a4, a5, a6, a7;
  logic signed [ccol_pkg::QW-1:0]    b3, c3, b4, b5, b6, b7;

  ccol_pkg::status_t                 st4, st5, st6, st7;
  logic [ccol_pkg::MAG_W-1:0]        bm, cm;
  logic                              csg4, csg5, csg6;

  logic [ccol_pkg::MAG_W-1:0]        bll, blh, bhh, all, alh, ahl, ahh;
  logic [ccol_pkg::PW-1:0]           bb6, ac6;
  logic [ccol_pkg::SQ_W-1:0]         disc7;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= d_in.valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  // relative motion and summed radius
  always_ff @(posedge clk) begin
    if (en) begin
      dx   <= {d_in.first_pos_x[ccol_pkg::POS_W-1], d_in.first_pos_x}
            - {d_in.second_pos_x[ccol_pkg::POS_W-1], d_in.second_pos_x};
      dy   <= {d_in.first_pos_y[ccol_pkg::POS_W-1], d_in.first_pos_y}
            - {d_in.second_pos_y[ccol_pkg::POS_W-1], d_in.second_pos_y};
      vx   <= {d_in.first_vel_x[ccol_pkg::POS_W-1], d_in.first_vel_x}
            - {d_in.second_vel_x[ccol_pkg::POS_W-1], d_in.second_vel_x};
      vy   <= {d_in.first_vel_y[ccol_pkg::POS_W-1], d_in.first_vel_y}
            - {d_in.second_vel_y[ccol_pkg::POS_W-1], d_in.second_vel_y};
      rs   <= {1'b0, d_in.first_radius} + {1'b0, d_in.second_radius};
      now1 <= d_in.current_time;
    end
  end

  // square and cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      pvx  <= vx * vx;
      pvy  <= vy * vy;
      pbx  <= dx * vx;
      pby  <= dy * vy;
      pdx  <= dx * dx;
      pdy  <= dy * dy;
      prr  <= rs * rs;
      now2 <= now1;
    end
  end

  // form a, b and c
  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= $unsigned(pvx) + $unsigned(pvy);
      b3   <= ccol_pkg::QW'(pbx) + ccol_pkg::QW'(pby);
      c3   <= ccol_pkg::QW'(pdx) + ccol_pkg::QW'(pdy) - ccol_pkg::QW'(prr);
      now3 <= now2;
    end
  end

  // take magnitudes; flag no relative motion
  always_ff @(posedge clk) begin
    if (en) begin
      st4  <= (a3 == '0) ? ccol_pkg::ST_STILL : ccol_pkg::ST_HIT;
      bm   <= ccol_pkg::MAG_W'(b3[ccol_pkg::QW-1] ? -b3 : b3);
      cm   <= ccol_pkg::MAG_W'(c3[ccol_pkg::QW-1] ? -c3 : c3);
      csg4 <= c3[ccol_pkg::QW-1];
      a4   <= a3;
      b4   <= b3;
      now4 <= now3;
    end
  end

  // partial products of b*b and a*|c|
  always_ff @(posedge clk) begin
    if (en) begin
      bll  <= bm[ccol_pkg::HALF_W-1:0] * bm[ccol_pkg::HALF_W-1:0];
      blh  <= bm[ccol_pkg::HALF_W-1:0] * bm[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W];
      bhh  <= bm[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W]
            * bm[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W];
      all  <= a4[ccol_pkg::HALF_W-1:0] * cm[ccol_pkg::HALF_W-1:0];
      alh  <= a4[ccol_pkg::HALF_W-1:0] * cm[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W];
      ahl  <= a4[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W] * cm[ccol_pkg::HALF_W-1:0];
      ahh  <= a4[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W]
            * cm[ccol_pkg::MAG_W-1:ccol_pkg::HALF_W];
      st5  <= st4;
      csg5 <= csg4;
      a5   <= a4;
      b5   <= b4;
      now5 <= now4;
    end
  end

  // sum partial products
  always_ff @(posedge clk) begin
    if (en) begin
      bb6  <= (ccol_pkg::PW'(bhh) << ccol_pkg::MAG_W)
            + (ccol_pkg::PW'(blh) << (ccol_pkg::HALF_W + 1))
            + ccol_pkg::PW'(bll);
      ac6  <= (ccol_pkg::PW'(ahh) << ccol_pkg::MAG_W)
            + ((ccol_pkg::PW'(alh) + ccol_pkg::PW'(ahl)) << ccol_pkg::HALF_W)
            + ccol_pkg::PW'(all);
      st6  <= st5;
      csg6 <= csg5;
      a6   <= a5;
      b6   <= b5;
      now6 <= now5;
    end
  end

  // discriminant b*b - a*c
  always_ff @(posedge clk) begin
    if (en) begin
      disc7 <= csg6 ? ccol_pkg::SQ_W'(bb6) + ccol_pkg::SQ_W'(ac6)
                    : ccol_pkg::SQ_W'(bb6) - ccol_pkg::SQ_W'(ac6);
      st7   <= st6;
      a7    <= a6;
      b7    <= b6;
      now7  <= now6;
    end
  end

  // load the first root cell; drop grazing or missing pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= v7;
    end
    if (en) begin
      d_out.rad       <= disc7;
      d_out.rem       <= '0;
      d_out.root      <= '0;
      d_out.side.st   <= (st7 == ccol_pkg::ST_HIT &&
                          (disc7[ccol_pkg::SQ_W-1] || disc7 == '0))
                         ? ccol_pkg::ST_MISS : st7;
      d_out.side.sat  <= 1'b0;
      d_out.side.a    <= a7;
      d_out.side.b    <= b7;
      d_out.side.now  <= now7;
    end
  end

endmodule

// ===== sv/ccol_sqrt_cell.sv =====
// One square-root cell: settles one root bit from two radicand bits.
module ccol_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ccol_pkg::sq_t d_in,
  output ccol_pkg::sq_t d_out
);

  logic [ccol_pkg::SQR_W-1:0] remsh, trial;
  logic                       ge;
  ccol_pkg::sq_t              nxt;

  // trial subtract of (root << 2) | 1
  always_comb begin
    remsh     = {d_in.rem[ccol_pkg::SQR_W-3:0], d_in.rad[ccol_pkg::SQ_W-1 -: 2]};
    trial     = {1'b0, d_in.root, 2'b01};
    ge        = (remsh >= trial);
    nxt       = d_in;
    nxt.rem   = ge ? remsh - trial : remsh;
    nxt.root  = {d_in.root[ccol_pkg::ROOT_W-2:0], ge};
    nxt.rad   = {d_in.rad[ccol_pkg::SQ_W-3:0], 2'b00};
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== sv/ccol_div_cell.sv =====
// One divider cell: settles one quotient bit by restoring subtraction.
module ccol_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ccol_pkg::dv_t d_in,
  output ccol_pkg::dv_t d_out
);

  logic [ccol_pkg::DVR_W-1:0] r2, dvs;
  logic                       ge;
  ccol_pkg::dv_t              nxt;

  // bring in the next dividend bit and try the divisor
  always_comb begin
    r2       = {d_in.rem[ccol_pkg::DVR_W-2:0], d_in.dend[ccol_pkg::TIME_W-1]};
    dvs      = {2'b00, d_in.side.a};
    ge       = (r2 >= dvs);
    nxt      = d_in;
    nxt.rem  = ge ? r2 - dvs : r2;
    nxt.quo  = {d_in.quo[ccol_pkg::TIME_W-2:0], ge};
    nxt.dend = {d_in.dend[ccol_pkg::TIME_W-2:0], 1'b0};
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== dv/circle_collision_time_test.sv =====
// Testbench for circle_collision_time: directed table, random pairs, contact-time predictor.
`timescale 1ns / 1ps

module circle_collision_time_test;

  localparam int ONE          = 1 << ccol_pkg::FRAC_BITS;
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 270;
  localparam logic [ccol_pkg::TIME_W-1:0] TIME_ALL = '1;

  typedef struct {
    logic [ccol_pkg::POS_W-1:0]  first_pos_x;
    logic [ccol_pkg::POS_W-1:0]  first_pos_y;
    logic [ccol_pkg::POS_W-1:0]  first_vel_x;
    logic [ccol_pkg::POS_W-1:0]  first_vel_y;
    logic [ccol_pkg::RAD_W-1:0]  first_radius;
    logic [ccol_pkg::POS_W-1:0]  second_pos_x;
    logic [ccol_pkg::POS_W-1:0]  second_pos_y;
    logic [ccol_pkg::POS_W-1:0]  second_vel_x;
    logic [ccol_pkg::POS_W-1:0]  second_vel_y;
    logic [ccol_pkg::RAD_W-1:0]  second_radius;
    logic [ccol_pkg::TIME_W-1:0] current_time;
  } pair_t;

  typedef struct {
    logic                        hit;
    ccol_pkg::status_t           status;
    logic [ccol_pkg::TIME_W-1:0] event_time;
  } contact_t;

  typedef struct {
    pair_t    pair;
    bit       known;
    contact_t want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [ccol_pkg::LEAD_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_ready;
  pair_t drv;
  logic out_valid;
  logic out_ready;
  logic hit;
  logic [1:0] status;
  logic [ccol_pkg::TIME_W-1:0] event_time;

  contact_t pending_contacts[$];
  logic [ccol_pkg::LEAD_W-1:0] lead_time;
  int fails = 0;
  int cycles = 0;
  int burst_left;
  row_t rows[13];

  circle_collision_time uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_pos_x(drv.first_pos_x), .first_pos_y(drv.first_pos_y),
    .first_vel_x(drv.first_vel_x), .first_vel_y(drv.first_vel_y),
    .first_radius(drv.first_radius),
    .second_pos_x(drv.second_pos_x), .second_pos_y(drv.second_pos_y),
    .second_vel_x(drv.second_vel_x), .second_vel_y(drv.second_vel_y),
    .second_radius(drv.second_radius),
    .current_time(drv.current_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .status(status), .event_time(event_time)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Solve the contact quadratic exactly on wide signed integers
  function automatic contact_t predict_contact(pair_t p,
                                               logic [ccol_pkg::LEAD_W-1:0] lead);
    logic signed [191:0] dx, dy, vx, vy, rsum, a, b, c, disc, root, cand, num, quo;
    logic [ccol_pkg::TIME_W-1:0] lead_t;
    logic [ccol_pkg::TIME_W:0] sum;
    contact_t r;
    r.hit = 1'b0;
    r.event_time = '0;
    dx = $signed(p.first_pos_x);
    dx = dx - $signed(p.second_pos_x);
    dy = $signed(p.first_pos_y);
    dy = dy - $signed(p.second_pos_y);
    vx = $signed(p.first_vel_x);
    vx = vx - $signed(p.second_vel_x);
    vy = $signed(p.first_vel_y);
    vy = vy - $signed(p.second_vel_y);
    rsum = 0;
    rsum[ccol_pkg::RAD_W:0] = p.first_radius + {1'b0, p.second_radius};
    a = vx * vx + vy * vy;
    if (a == 0) begin
      r.status = ccol_pkg::ST_STILL;
      return r;
    end
    b = dx * vx + dy * vy;
    c = dx * dx + dy * dy - rsum * rsum;
    disc = b * b - a * c;
    if (disc <= 0) begin
      r.status = ccol_pkg::ST_MISS;
      return r;
    end
    root = 0;
    for (int i = 67; i >= 0; i--) begin
      cand = root;
      cand[i] = 1'b1;
      if (cand * cand <= disc) root = cand;
    end
    num = -b - root;
    if (num <= 0) begin
      r.status = ccol_pkg::ST_SOON;
      return r;
    end
    quo = (num <<< ccol_pkg::FRAC_BITS) / a;
    lead_t = quo > $signed({144'b0, TIME_ALL}) ? TIME_ALL : quo[ccol_pkg::TIME_W-1:0];
    if (lead_t <= lead) begin
      r.status = ccol_pkg::ST_SOON;
      return r;
    end
    sum = p.current_time + lead_t;
    r.hit = 1'b1;
    r.status = ccol_pkg::ST_HIT;
    r.event_time = sum[ccol_pkg::TIME_W] ? TIME_ALL : sum[ccol_pkg::TIME_W-1:0];
    return r;
  endfunction

  function automatic pair_t mk_pair(int fpx, int fpy, int fvx, int fvy, int fr,
                                    int spx, int spy, int svx, int svy, int sr,
                                    logic [ccol_pkg::TIME_W-1:0] now);
    pair_t p;
    p.first_pos_x = fpx;  p.first_pos_y = fpy;
    p.first_vel_x = fvx;  p.first_vel_y = fvy;
    p.first_radius = ccol_pkg::RAD_W'(fr);
    p.second_pos_x = spx; p.second_pos_y = spy;
    p.second_vel_x = svx; p.second_vel_y = svy;
    p.second_radius = ccol_pkg::RAD_W'(sr);
    p.current_time = now;
    return p;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly approaching pairs at modest scale, some full-range noise
  function automatic pair_t rand_pair();
    pair_t p;
    int mode, span, dxs, dys;
    mode = $urandom_range(0, 9);
    p.current_time = ccol_pkg::TIME_W'({$urandom, $urandom});
    if ($urandom_range(0, 15) == 0) p.current_time = TIME_ALL - $urandom_range(0, 1 << 20);
    if (mode < 2) begin
      p.first_pos_x = $urandom;  p.first_pos_y = $urandom;
      p.first_vel_x = $urandom;  p.first_vel_y = $urandom;
      p.second_pos_x = $urandom; p.second_pos_y = $urandom;
      p.second_vel_x = $urandom; p.second_vel_y = $urandom;
      p.first_radius = ccol_pkg::RAD_W'($urandom);
      p.second_radius = ccol_pkg::RAD_W'($urandom);
      return p;
    end
    span = 1 << $urandom_range(8, 28);
    p.first_pos_x = rand_span(span);
    p.first_pos_y = rand_span(span);
    p.second_pos_x = rand_span(span);
    p.second_pos_y = rand_span(span);
    p.first_vel_x = rand_span(1 << $urandom_range(4, 26));
    p.first_vel_y = rand_span(1 << $urandom_range(4, 26));
    p.first_radius = ccol_pkg::RAD_W'($urandom_range(0, 1 << $urandom_range(4, 24)));
    p.second_radius = ccol_pkg::RAD_W'($urandom_range(0, 1 << $urandom_range(4, 24)));
    if (mode < 4) begin
      p.second_vel_x = rand_span(1 << 20);
      p.second_vel_y = rand_span(1 << 20);
    end else begin
      // steer the second circle so the pair closes in
      dxs = $signed(p.first_pos_x) - $signed(p.second_pos_x);
      dys = $signed(p.first_pos_y) - $signed(p.second_pos_y);
      span = $urandom_range(0, 10);
      p.second_vel_x = $signed(p.first_vel_x) + (dxs >>> span) + rand_span(mode);
      p.second_vel_y = $signed(p.first_vel_y) + (dys >>> span) + rand_span(mode);
    end
    return p;
  endfunction

  // Present one request and hold it until taken
  task automatic send_pair(pair_t p, bit known, contact_t want);
    contact_t expected;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    drv = p;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    expected = known ? want : predict_contact(p, lead_time);
    pending_contacts = {pending_contacts, expected};
    @(negedge clk);
    burst_left--;
  endtask

  // Drain the pipeline, then load a new lead time
  task automatic set_lead(logic [ccol_pkg::LEAD_W-1:0] value);
    in_valid = 1'b0;
    burst_left = 0;
    wait (pending_contacts.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    lead_time = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Stall the result side on its own pattern
  always @(negedge clk) begin
    case ((cycles / 300) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= ((cycles % 7) != 3);
    endcase
  end

  // Compare each result with the oldest expected contact
  always @(posedge clk) begin
    contact_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_contacts.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        want = pending_contacts.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, hit);
          fails++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
        if (event_time !== want.event_time) begin
          $error("event_time: expected %0h, got %0h", want.event_time, event_time);
          fails++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    contact_t none;
    burst_left = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    lead_time = 1;
    drv = mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    none.hit = 1'b0;
    none.event_time = '0;
    none.status = ccol_pkg::ST_STILL;

    // Directed cases: still pairs, head-on hit, separating, miss, grazing, saturation
    rows[0].pair = mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    rows[1].pair = mk_pair(5, -7, 32'h7fffffff, 32'h80000000, 3,
                           9, 4, 32'h7fffffff, 32'h80000000, 1, 48'd77);
    rows[2].pair = mk_pair(-10 * ONE, 0, ONE, 0, ONE, 10 * ONE, 0, -ONE, 0, ONE,
                           48'(100 * ONE));
    rows[3].pair = mk_pair(-10 * ONE, 0, -ONE, 0, ONE, 10 * ONE, 0, ONE, 0, ONE, 48'd5);
    rows[4].pair = mk_pair(-10 * ONE, 0, ONE, 0, ONE, 10 * ONE, 100 * ONE, -ONE, 0, ONE,
                           48'd5);
    rows[5].pair = mk_pair(-10 * ONE, 0, ONE, 0, ONE, 10 * ONE, 2 * ONE, -ONE, 0, ONE,
                           48'd5);
    rows[6].pair = mk_pair(-10 * ONE, 0, ONE, 0, ONE, 10 * ONE, 0, -ONE, 0, ONE, TIME_ALL);
    rows[7].pair = mk_pair(0, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 48'd9);
    rows[8].pair = mk_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                           24'hffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                           32'h7fffffff, 24'hffffff, '0);
    rows[9].pair = mk_pair(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                           24'hffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 24'hffffff, TIME_ALL);
    rows[10].pair = mk_pair(0, 0, 0, 0, 24'hffffff, 0, 0, 0, 0, 24'hffffff, TIME_ALL);
    rows[11].pair = mk_pair(-1000 * ONE, 0, 1 << 30, 0, 0, 1000 * ONE, 0, -(1 << 30), 0,
                            0, 48'd3);
    rows[12].pair = mk_pair(-3, 0, 1, 0, 0, 0, 0, -1, 0, 0, 48'd1);
    foreach (rows[i]) begin
      rows[i].known = 1'b0;
      rows[i].want = none;
    end
    foreach (rows[i]) if (i < 8 || i == 10) rows[i].known = 1'b1;
    rows[2].want.hit = 1'b1;
    rows[2].want.status = ccol_pkg::ST_HIT;
    rows[2].want.event_time = 109 * ONE;
    rows[3].want.status = ccol_pkg::ST_SOON;
    rows[4].want.status = ccol_pkg::ST_MISS;
    rows[5].want.status = ccol_pkg::ST_MISS;
    rows[6].want.hit = 1'b1;
    rows[6].want.status = ccol_pkg::ST_HIT;
    rows[6].want.event_time = TIME_ALL;
    rows[7].want.status = ccol_pkg::ST_SOON;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].want);

    // Random phases across lead-time settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_lead(16'd0);
        1: set_lead(16'hffff);
        2: set_lead(16'($urandom));
        default: set_lead(16'd1);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_pair(rand_pair(), 1'b0, none);
    end

    in_valid = 1'b0;
    wait (pending_contacts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
